FILE: hw/rtl/kmsd_pkg.sv
// Package with the shared types, codes and key constants of the KLV deframer.
package kmsd_pkg;

	localparam logic [2:0] PH_KEY  = 3'd0;
	localparam logic [2:0] PH_LEN  = 3'd1;
	localparam logic [2:0] PH_VAL  = 3'd2;
	localparam logic [2:0] PH_LTAG = 3'd3;
	localparam logic [2:0] PH_LLEN = 3'd4;
	localparam logic [2:0] PH_LVAL = 3'd5;
	localparam logic [2:0] PH_PHDR = 3'd6;
	localparam logic [2:0] PH_PENT = 3'd7;

	localparam logic [1:0] K_PLAIN  = 2'd0;
	localparam logic [1:0] K_LOCAL  = 2'd1;
	localparam logic [1:0] K_PRIMER = 2'd2;
	localparam logic [1:0] K_FILLER = 2'd3;

	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_NULLTAG = 2'd1;
	localparam logic [1:0] ERR_OVERRUN = 2'd2;

	localparam logic [1:0] REG_MXF_MODE     = 2'd0;
	localparam logic [1:0] REG_DUMP_FILLER  = 2'd1;
	localparam logic [1:0] REG_LIMIT_ENABLE = 2'd2;
	localparam logic [1:0] REG_LIMIT_BYTES  = 2'd3;

	localparam logic [7:0] LOCAL_SET_MARK = 8'h53;
	localparam int         QUEUE_DEPTH    = 2;

	typedef struct packed {
		logic [7:0]  byte_out;
		logic [2:0]  byte_role;
		logic [1:0]  packet_kind;
		logic        shown;
		logic [23:0] value_offset;
		logic [23:0] packet_length;
		logic [15:0] item_tag;
		logic        last_of_packet;
		logic [1:0]  error_code;
	} result_t;

	typedef struct packed {
		logic        mxf_mode;
		logic        dump_filler;
		logic        limit_enable;
		logic [31:0] limit_bytes;
	} cfg_t;

	function automatic logic [7:0] primer_key(input logic [3:0] i);
		logic [7:0] k;
		case (i)
			4'd0: k = 8'h06;  4'd1: k = 8'h0e;  4'd2: k = 8'h2b;  4'd3: k = 8'h34;
			4'd4: k = 8'h02;  4'd5: k = 8'h05;  4'd6: k = 8'h01;  4'd7: k = 8'h01;
			4'd8: k = 8'h0d;  4'd9: k = 8'h01;  4'd10: k = 8'h02; 4'd11: k = 8'h01;
			4'd12: k = 8'h01; 4'd13: k = 8'h05; 4'd14: k = 8'h01; default: k = 8'h00;
		endcase
		return k;
	endfunction

	function automatic logic [7:0] filler_key(input logic [3:0] i);
		logic [7:0] k;
		case (i)
			4'd0: k = 8'h06;  4'd1: k = 8'h0e;  4'd2: k = 8'h2b;  4'd3: k = 8'h34;
			4'd4: k = 8'h01;  4'd5: k = 8'h01;  4'd6: k = 8'h01;  4'd7: k = 8'h01;
			4'd8: k = 8'h03;  4'd9: k = 8'h01;  4'd10: k = 8'h02; 4'd11: k = 8'h10;
			4'd12: k = 8'h01; default: k = 8'h00;
		endcase
		return k;
	endfunction

endpackage

FILE: hw/rtl/klv_mxf_stream_deframer.sv
// Top level of the KLV/MXF stream deframer.
// Takes one byte per cycle, when not stalled, and returns one tagged result per byte, in order,
// registered first in a two-entry byte queue in front of the framing engine and then in its result
// register; the queue lets input and output stall independently, and the framing state machine,
// which tags each byte as it is popped, sets the rate of one byte per clock while neither side stalls.
module klv_mxf_stream_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  byte_out,
	output logic [2:0]  byte_role,
	output logic [1:0]  packet_kind,
	output logic        shown,
	output logic [23:0] value_offset,
	output logic [23:0] packet_length,
	output logic [15:0] item_tag,
	output logic        last_of_packet,
	output logic [1:0]  error_code,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	kmsd_pkg::cfg_t    cfg_q;
	kmsd_pkg::result_t res;
	logic              q_valid, q_pop;
	logic [7:0]        q_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mxf_mode     <= 1'b1;
			cfg_q.dump_filler  <= 1'b0;
			cfg_q.limit_enable <= 1'b0;
			cfg_q.limit_bytes  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				kmsd_pkg::REG_MXF_MODE:     cfg_q.mxf_mode     <= cfg_data[0];
				kmsd_pkg::REG_DUMP_FILLER:  cfg_q.dump_filler  <= cfg_data[0];
				kmsd_pkg::REG_LIMIT_ENABLE: cfg_q.limit_enable <= cfg_data[0];
				default:                    cfg_q.limit_bytes  <= cfg_data;
			endcase
		end
	end

	kmsd_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_byte(data_byte),
		.q_valid(q_valid), .q_pop(q_pop), .q_byte(q_byte)
	);

	kmsd_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.q_valid(q_valid), .q_pop(q_pop), .q_byte(q_byte),
		.out_valid(out_valid), .out_stall(out_stall), .res_q(res)
	);

	assign byte_out       = res.byte_out;
	assign byte_role      = res.byte_role;
	assign packet_kind    = res.packet_kind;
	assign shown          = res.shown;
	assign value_offset   = res.value_offset;
	assign packet_length  = res.packet_length;
	assign item_tag       = res.item_tag;
	assign last_of_packet = res.last_of_packet;
	assign error_code     = res.error_code;

endmodule

FILE: hw/rtl/kmsd_front.sv
// Front end: accepts stream bytes and queues them for the framing engine.
module kmsd_front (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       q_valid,
	input  logic       q_pop,
	output logic [7:0] q_byte
);

	logic [7:0] mem_q [kmsd_pkg::QUEUE_DEPTH];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       push;

	assign in_stall = (count_q == 2'(kmsd_pkg::QUEUE_DEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != 2'd0);
	assign q_byte   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(q_pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= 2'd2)
		else $error("queue count out of range");
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !q_pop) |=> count_q == $past(count_q) + 2'd1)
		else $error("queue count missed a push");

endmodule

FILE: hw/rtl/kmsd_back.sv
// Back end: framing state machine that tags each byte and holds the result register.
module kmsd_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  kmsd_pkg::cfg_t          cfg,
	input  logic                    q_valid,
	output logic                    q_pop,
	input  logic [7:0]              q_byte,
	output logic                    out_valid,
	input  logic                    out_stall,
	output kmsd_pkg::result_t       res_q
);

	logic [2:0]  phase_q;
	logic [4:0]  fcnt_q;
	logic        pm_q, fm_q;
	logic [1:0]  kind_q;
	logic [23:0] len_q, off_q, vleft_q;
	logic [24:0] cons_q;
	logic [15:0] tag_q, ilen_q;
	logic [31:0] pleft_q;
	logic        ovalid_q;

	logic [2:0]  phase_d;
	logic [4:0]  fcnt_d;
	logic        pm_d, fm_d;
	logic [1:0]  kind_d;
	logic [23:0] len_d, off_d, vleft_d;
	logic [24:0] cons_d;
	logic [15:0] tag_d, ilen_d;
	logic [31:0] pleft_d;
	kmsd_pkg::result_t r;

	logic [3:0]  kidx;
	logic [7:0]  b;
	logic [25:0] total;
	logic [24:0] cons_inc;
	logic [23:0] vlen;

	assign b         = q_byte;
	assign kidx      = fcnt_q[3:0];
	assign out_valid = ovalid_q;
	assign q_pop     = q_valid && (!ovalid_q || !out_stall);
	assign cons_inc  = cons_q + 25'd1;
	assign total     = {1'b0, cons_inc} + {10'd0, ilen_d};

	always_comb begin
		phase_d = phase_q; fcnt_d = fcnt_q; pm_d = pm_q; fm_d = fm_q;
		kind_d = kind_q; len_d = len_q; off_d = off_q; vleft_d = vleft_q;
		cons_d = cons_q; tag_d = tag_q; ilen_d = ilen_q; pleft_d = pleft_q;
		vlen = 24'd0;
		r = '0;
		r.byte_out = b;
		r.packet_kind = kind_q;
		r.value_offset = {19'd0, fcnt_q};
		r.packet_length = len_q;
		r.error_code = kmsd_pkg::ERR_NONE;
		unique case (phase_q)
			kmsd_pkg::PH_KEY: begin
				if (kidx == 4'd0) begin
					pm_d = 1'b1; fm_d = 1'b1; kind_d = kmsd_pkg::K_PLAIN; len_d = '0;
				end
				pm_d = pm_d && (b == kmsd_pkg::primer_key(kidx));
				fm_d = fm_d && (b == kmsd_pkg::filler_key(kidx));
				if (kidx == 4'd5) begin
					kind_d = (b == kmsd_pkg::LOCAL_SET_MARK) ? kmsd_pkg::K_LOCAL
						: kmsd_pkg::K_PLAIN;
				end
				r.byte_role = kmsd_pkg::PH_KEY;
				r.packet_kind = kmsd_pkg::K_PLAIN;
				r.value_offset = {20'd0, kidx};
				r.packet_length = '0;
				if (kidx == 4'd15) begin
					if (!cfg.mxf_mode) begin
						kind_d = kmsd_pkg::K_PLAIN;
					end else if (kind_d != kmsd_pkg::K_LOCAL) begin
						if (pm_d) kind_d = kmsd_pkg::K_PRIMER;
						else if (fm_d) kind_d = kmsd_pkg::K_FILLER;
						else kind_d = kmsd_pkg::K_PLAIN;
					end
					phase_d = kmsd_pkg::PH_LEN; fcnt_d = '0;
				end else begin
					fcnt_d = {1'b0, kidx + 4'd1};
				end
			end
			kmsd_pkg::PH_LEN: begin
				len_d = {len_q[15:0], b};
				r.byte_role = kmsd_pkg::PH_LEN;
				r.packet_length = len_d;
				if (fcnt_q >= 5'd3) begin
					fcnt_d = '0;
					if (kind_q == kmsd_pkg::K_PRIMER) begin
						pleft_d = '0; phase_d = kmsd_pkg::PH_PHDR;
					end else if (len_d == 24'd0) begin
						r.last_of_packet = 1'b1; phase_d = kmsd_pkg::PH_KEY;
					end else if (kind_q == kmsd_pkg::K_LOCAL) begin
						cons_d = '0; phase_d = kmsd_pkg::PH_LTAG;
					end else begin
						off_d = '0; phase_d = kmsd_pkg::PH_VAL;
					end
				end else begin
					fcnt_d = fcnt_q + 5'd1;
				end
			end
			kmsd_pkg::PH_VAL: begin
				r.byte_role = kmsd_pkg::PH_VAL;
				r.value_offset = off_q;
				if (kind_q == kmsd_pkg::K_FILLER) r.shown = cfg.dump_filler;
				else if (kind_q == kmsd_pkg::K_PLAIN && !cfg.mxf_mode && cfg.limit_enable)
					r.shown = ({8'd0, off_q} < cfg.limit_bytes);
				else r.shown = 1'b1;
				if ({1'b0, off_q} + 25'd1 >= {1'b0, len_q}) begin
					r.last_of_packet = 1'b1; phase_d = kmsd_pkg::PH_KEY; fcnt_d = '0;
				end else begin
					off_d = off_q + 24'd1;
				end
			end
			kmsd_pkg::PH_LTAG: begin
				tag_d = (fcnt_q == 5'd0) ? {b, 8'd0} : {tag_q[15:8], b};
				cons_d = cons_inc;
				r.byte_role = kmsd_pkg::PH_LTAG;
				r.item_tag = tag_d;
				if (fcnt_q >= 5'd1) begin
					if (tag_d == 16'd0) r.error_code = kmsd_pkg::ERR_NULLTAG;
					phase_d = kmsd_pkg::PH_LLEN; fcnt_d = '0;
				end else begin
					fcnt_d = 5'd1;
				end
			end
			kmsd_pkg::PH_LLEN: begin
				ilen_d = (fcnt_q == 5'd0) ? {b, 8'd0} : {ilen_q[15:8], b};
				cons_d = cons_inc;
				r.byte_role = kmsd_pkg::PH_LLEN;
				r.item_tag = tag_q;
				if (fcnt_q >= 5'd1) begin
					if (total > {2'd0, len_q}) r.error_code = kmsd_pkg::ERR_OVERRUN;
					if (total < {2'd0, len_q}) vlen = {8'd0, ilen_d};
					else if (cons_inc <= {1'b0, len_q}) vlen = 24'(({1'b0, len_q} - cons_inc));
					else vlen = '0;
					cons_d = total[24:0];
					fcnt_d = '0;
					if (vlen != 24'd0) begin
						vleft_d = vlen; off_d = '0; phase_d = kmsd_pkg::PH_LVAL;
					end else if (total >= {2'd0, len_q}) begin
						r.last_of_packet = 1'b1; phase_d = kmsd_pkg::PH_KEY;
					end else begin
						phase_d = kmsd_pkg::PH_LTAG;
					end
				end else begin
					fcnt_d = 5'd1;
				end
			end
			kmsd_pkg::PH_LVAL: begin
				r.byte_role = kmsd_pkg::PH_LVAL;
				r.value_offset = off_q;
				r.shown = 1'b1;
				r.item_tag = tag_q;
				vleft_d = vleft_q - 24'd1;
				if (vleft_d == 24'd0) begin
					fcnt_d = '0;
					if (cons_q >= {1'b0, len_q}) begin
						r.last_of_packet = 1'b1; phase_d = kmsd_pkg::PH_KEY;
					end else begin
						phase_d = kmsd_pkg::PH_LTAG;
					end
				end else begin
					off_d = off_q + 24'd1;
				end
			end
			kmsd_pkg::PH_PHDR: begin
				r.byte_role = kmsd_pkg::PH_PHDR;
				if (fcnt_q < 5'd4) pleft_d = {pleft_q[23:0], b};
				if (fcnt_q >= 5'd7) begin
					fcnt_d = '0;
					if (pleft_d == 32'd0) begin
						r.last_of_packet = 1'b1; phase_d = kmsd_pkg::PH_KEY;
					end else begin
						phase_d = kmsd_pkg::PH_PENT;
					end
				end else begin
					fcnt_d = fcnt_q + 5'd1;
				end
			end
			kmsd_pkg::PH_PENT: begin
				r.byte_role = kmsd_pkg::PH_PENT;
				if (fcnt_q >= 5'd17) begin
					fcnt_d = '0;
					pleft_d = pleft_q - 32'd1;
					if (pleft_d == 32'd0) begin
						r.last_of_packet = 1'b1; phase_d = kmsd_pkg::PH_KEY;
					end
				end else begin
					fcnt_d = fcnt_q + 5'd1;
				end
			end
			default: r.byte_role = kmsd_pkg::PH_KEY;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q <= r;
			len_q <= len_d; off_q <= off_d; vleft_q <= vleft_d; cons_q <= cons_d;
			tag_q <= tag_d; ilen_q <= ilen_d; pleft_q <= pleft_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= kmsd_pkg::PH_KEY;
			fcnt_q   <= '0;
			pm_q     <= 1'b1;
			fm_q     <= 1'b1;
			kind_q   <= kmsd_pkg::K_PLAIN;
			ovalid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				phase_q <= phase_d; fcnt_q <= fcnt_d; pm_q <= pm_d; fm_q <= fm_d;
				kind_q <= kind_d;
				ovalid_q <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && out_stall) |=> ovalid_q)
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == kmsd_pkg::PH_LTAG || phase_q == kmsd_pkg::PH_LLEN) |-> fcnt_q <= 5'd1)
		else $error("local header byte count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == kmsd_pkg::PH_LVAL) |-> vleft_q != 24'd0)
		else $error("local value entered with nothing left");

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the KLV/MXF stream deframer with its own framing predictor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_BYTES = 210;
	localparam logic [7:0] PRIMER_UL [16] = '{8'h06, 8'h0e, 8'h2b, 8'h34, 8'h02, 8'h05,
		8'h01, 8'h01, 8'h0d, 8'h01, 8'h02, 8'h01, 8'h01, 8'h05, 8'h01, 8'h00};
	localparam logic [7:0] FILLER_UL [16] = '{8'h06, 8'h0e, 8'h2b, 8'h34, 8'h01, 8'h01,
		8'h01, 8'h01, 8'h03, 8'h01, 8'h02, 8'h10, 8'h01, 8'h00, 8'h00, 8'h00};

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [7:0] data_byte;
	kmsd_pkg::result_t got;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;

	klv_mxf_stream_deframer dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .out_valid(out_valid), .out_stall(out_stall),
		.byte_out(got.byte_out), .byte_role(got.byte_role), .packet_kind(got.packet_kind),
		.shown(got.shown), .value_offset(got.value_offset), .packet_length(got.packet_length),
		.item_tag(got.item_tag), .last_of_packet(got.last_of_packet),
		.error_code(got.error_code), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	logic [7:0] byte_queue[$];
	kmsd_pkg::result_t expected_results[$];
	int error_count = 0;
	int bytes_checked = 0;
	int packets_seen [4] = '{0, 0, 0, 0};
	int cycle_count = 0;
	bit idle_on = 1;
	bit hold_start = 0;
	int hold_left = 0;

	// Configuration mirror.
	logic c_mxf = 1, c_dfill = 0, c_lim_en = 0;
	logic [31:0] c_lim = 0;

	// Framing state of the predictor.
	logic [2:0] ph = kmsd_pkg::PH_KEY;
	int unsigned fcnt = 0;
	logic pm = 1, fm = 1;
	logic [1:0] kind_q = kmsd_pkg::K_PLAIN;
	logic [23:0] len_acc = 0, off = 0, ileft = 0;
	logic [24:0] consumed = 0;
	logic [15:0] tag_r = 0, ilen = 0;
	logic [31:0] pent = 0;

	function automatic kmsd_pkg::result_t frame_byte(input logic [7:0] b);
		kmsd_pkg::result_t r;
		int unsigned idx, s, total, vlen;
		idx = fcnt & 31;
		r = '0;
		r.byte_out = b;
		r.byte_role = ph;
		r.packet_kind = kind_q;
		r.value_offset = 24'(idx);
		r.packet_length = len_acc;
		case (ph)
			kmsd_pkg::PH_KEY: begin
				idx = idx & 15;
				if (idx == 0) begin
					pm = 1; fm = 1; kind_q = kmsd_pkg::K_PLAIN; len_acc = 0;
				end
				pm &= (b == PRIMER_UL[idx]);
				fm &= (b == FILLER_UL[idx]);
				if (idx == 5) kind_q = (b == kmsd_pkg::LOCAL_SET_MARK) ? kmsd_pkg::K_LOCAL
					: kmsd_pkg::K_PLAIN;
				r.packet_kind = kmsd_pkg::K_PLAIN;
				r.value_offset = 24'(idx);
				r.packet_length = 0;
				if (idx == 15) begin
					if (!c_mxf) kind_q = kmsd_pkg::K_PLAIN;
					else if (kind_q != kmsd_pkg::K_LOCAL)
						kind_q = pm ? kmsd_pkg::K_PRIMER
							: (fm ? kmsd_pkg::K_FILLER : kmsd_pkg::K_PLAIN);
					ph = kmsd_pkg::PH_LEN; fcnt = 0;
				end else fcnt = idx + 1;
			end
			kmsd_pkg::PH_LEN: begin
				len_acc = {len_acc[15:0], b};
				r.packet_length = len_acc;
				if (idx >= 3) begin
					fcnt = 0;
					if (kind_q == kmsd_pkg::K_PRIMER) begin
						pent = 0; ph = kmsd_pkg::PH_PHDR;
					end else if (len_acc == 0) begin
						r.last_of_packet = 1; ph = kmsd_pkg::PH_KEY;
					end else if (kind_q == kmsd_pkg::K_LOCAL) begin
						consumed = 0; ph = kmsd_pkg::PH_LTAG;
					end else begin
						off = 0; ph = kmsd_pkg::PH_VAL;
					end
				end else fcnt = idx + 1;
			end
			kmsd_pkg::PH_VAL: begin
				r.value_offset = off;
				if (kind_q == kmsd_pkg::K_FILLER) r.shown = c_dfill;
				else if (kind_q == kmsd_pkg::K_PLAIN && !c_mxf && c_lim_en)
					r.shown = (off < c_lim);
				else r.shown = 1;
				if (int'(off) + 1 >= int'(len_acc)) begin
					r.last_of_packet = 1; ph = kmsd_pkg::PH_KEY; fcnt = 0;
				end else off = off + 1;
			end
			kmsd_pkg::PH_LTAG: begin
				if (idx == 0) tag_r = {b, 8'h00};
				else tag_r[7:0] = b;
				consumed = consumed + 1;
				r.item_tag = tag_r;
				if (idx >= 1) begin
					if (tag_r == 0) r.error_code = kmsd_pkg::ERR_NULLTAG;
					ph = kmsd_pkg::PH_LLEN; fcnt = 0;
				end else fcnt = 1;
			end
			kmsd_pkg::PH_LLEN: begin
				if (idx == 0) ilen = {b, 8'h00};
				else ilen[7:0] = b;
				consumed = consumed + 1;
				r.item_tag = tag_r;
				if (idx >= 1) begin
					s = consumed;
					total = s + ilen;
					if (total > len_acc) r.error_code = kmsd_pkg::ERR_OVERRUN;
					if (total < len_acc) vlen = ilen;
					else if (s <= len_acc) vlen = len_acc - s;
					else vlen = 0;
					consumed = total[24:0];
					fcnt = 0;
					if (vlen != 0) begin
						ileft = vlen[23:0]; off = 0; ph = kmsd_pkg::PH_LVAL;
					end else if (total >= len_acc) begin
						r.last_of_packet = 1; ph = kmsd_pkg::PH_KEY;
					end else ph = kmsd_pkg::PH_LTAG;
				end else fcnt = 1;
			end
			kmsd_pkg::PH_LVAL: begin
				r.value_offset = off;
				r.shown = 1;
				r.item_tag = tag_r;
				ileft = ileft - 1;
				if (ileft == 0) begin
					fcnt = 0;
					if (consumed >= len_acc) begin
						r.last_of_packet = 1; ph = kmsd_pkg::PH_KEY;
					end else ph = kmsd_pkg::PH_LTAG;
				end else off = off + 1;
			end
			kmsd_pkg::PH_PHDR: begin
				if (idx < 4) pent = {pent[23:0], b};
				if (idx >= 7) begin
					fcnt = 0;
					if (pent == 0) begin
						r.last_of_packet = 1; ph = kmsd_pkg::PH_KEY;
					end else ph = kmsd_pkg::PH_PENT;
				end else fcnt = idx + 1;
			end
			default: begin
				if (idx >= 17) begin
					fcnt = 0;
					pent = pent - 1;
					if (pent == 0) begin
						r.last_of_packet = 1; ph = kmsd_pkg::PH_KEY;
					end
				end else fcnt = idx + 1;
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint unsigned g,
			input longint unsigned e);
		error_count++;
		$display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
			bytes_checked, what, g, e);
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout with %0d results outstanding", expected_results.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin : driver
		logic took;
		if (!arst_n) begin
			in_valid <= 0;
			data_byte <= 0;
		end else begin
			took = in_valid && !in_stall;
			if (took) begin
				expected_results.push_back(frame_byte(data_byte));
				void'(byte_queue.pop_front());
			end
			if (!in_valid || took) begin
				if (byte_queue.size() > 0 && !(idle_on && $urandom_range(0, 99) < 29)) begin
					in_valid <= 1;
					data_byte <= byte_queue[0];
				end else in_valid <= 0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) hold_left <= 0;
		else if (hold_start) hold_left <= 300;
		else if (hold_left > 0) hold_left <= hold_left - 1;
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		kmsd_pkg::result_t exp_r;
		if (!arst_n) out_stall <= 0;
		else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) report_mismatch("unexpected transaction", 0, 0);
				else begin
					exp_r = expected_results.pop_front();
					if (got.byte_out !== exp_r.byte_out)
						report_mismatch("byte_out", got.byte_out, exp_r.byte_out);
					if (got.byte_role !== exp_r.byte_role)
						report_mismatch("byte_role", got.byte_role, exp_r.byte_role);
					if (got.packet_kind !== exp_r.packet_kind)
						report_mismatch("packet_kind", got.packet_kind, exp_r.packet_kind);
					if (got.shown !== exp_r.shown)
						report_mismatch("shown", got.shown, exp_r.shown);
					if (got.value_offset !== exp_r.value_offset)
						report_mismatch("value_offset", got.value_offset, exp_r.value_offset);
					if (got.packet_length !== exp_r.packet_length)
						report_mismatch("packet_length", got.packet_length, exp_r.packet_length);
					if (got.item_tag !== exp_r.item_tag)
						report_mismatch("item_tag", got.item_tag, exp_r.item_tag);
					if (got.last_of_packet !== exp_r.last_of_packet)
						report_mismatch("last_of_packet", got.last_of_packet,
							exp_r.last_of_packet);
					if (got.error_code !== exp_r.error_code)
						report_mismatch("error_code", got.error_code, exp_r.error_code);
					if (exp_r.last_of_packet) packets_seen[exp_r.packet_kind]++;
					bytes_checked++;
				end
			end
			out_stall <= (hold_left > 0) || (idle_on && $urandom_range(0, 99) < 29);
		end
	end

	task automatic push_bytes(input int n);
		repeat (n) byte_queue.push_back(8'($urandom_range(0, 255)));
	endtask

	// Builds one packet of the given kind; a negative length or count is chosen at random.
	task automatic push_packet(input logic [1:0] sel, input int len, input int cnt);
		int used, s, total, vlen, room, il;
		logic [15:0] tg;
		logic [7:0] kb;
		if (len < 0) len = ($urandom_range(0, 19) == 0) ? $urandom_range(41, 300)
			: $urandom_range(0, 40);
		for (int i = 0; i < 16; i++) begin
			case (sel)
				kmsd_pkg::K_PRIMER: kb = PRIMER_UL[i];
				kmsd_pkg::K_FILLER: kb = FILLER_UL[i];
				default: begin
					kb = 8'($urandom_range(0, 255));
					if (sel == kmsd_pkg::K_PLAIN && i < 15 && $urandom_range(0, 3) == 0)
						kb = FILLER_UL[i];
					if (i == 5) kb = (sel == kmsd_pkg::K_LOCAL) ? kmsd_pkg::LOCAL_SET_MARK
						: ((kb == kmsd_pkg::LOCAL_SET_MARK) ? 8'h52 : kb);
				end
			endcase
			byte_queue.push_back(kb);
		end
		byte_queue.push_back(8'($urandom_range(0, 255)));
		byte_queue.push_back(len[23:16]);
		byte_queue.push_back(len[15:8]);
		byte_queue.push_back(len[7:0]);
		if (c_mxf && sel == kmsd_pkg::K_PRIMER) begin
			if (cnt < 0) cnt = $urandom_range(0, 3);
			byte_queue.push_back(cnt[31:24]);
			byte_queue.push_back(cnt[23:16]);
			byte_queue.push_back(cnt[15:8]);
			byte_queue.push_back(cnt[7:0]);
			push_bytes(4 + 18 * cnt);
		end else if (c_mxf && sel == kmsd_pkg::K_LOCAL) begin
			used = 0;
			while (len > 0) begin
				tg = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
				byte_queue.push_back(tg[15:8]);
				byte_queue.push_back(tg[7:0]);
				room = len - used - 4;
				if ($urandom_range(0, 5) == 0) il = $urandom_range(0, (room > 0 ? room : 0) + 10);
				else il = (room > 0) ? $urandom_range(0, room) : 0;
				byte_queue.push_back(il[15:8]);
				byte_queue.push_back(il[7:0]);
				s = used + 4;
				total = s + il;
				if (total < len) vlen = il;
				else if (s <= len) vlen = len - s;
				else vlen = 0;
				push_bytes(vlen);
				used = total;
				if (total >= len) break;
			end
		end else push_bytes(len);
	endtask

	task automatic wait_idle();
		while (byte_queue.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_config(input logic m, input logic d, input logic e,
			input logic [31:0] l);
		wait_idle();
		@(posedge clk);
		cfg_we <= 1; cfg_index <= kmsd_pkg::REG_MXF_MODE; cfg_data <= {31'd0, m};
		@(posedge clk);
		cfg_index <= kmsd_pkg::REG_DUMP_FILLER; cfg_data <= {31'd0, d};
		@(posedge clk);
		cfg_index <= kmsd_pkg::REG_LIMIT_ENABLE; cfg_data <= {31'd0, e};
		@(posedge clk);
		cfg_index <= kmsd_pkg::REG_LIMIT_BYTES; cfg_data <= l;
		@(posedge clk);
		cfg_we <= 0;
		c_mxf = m; c_dfill = d; c_lim_en = e; c_lim = l;
		@(negedge clk);
	endtask

	initial begin
		logic [34:0] settings [7];
		settings = '{{1'b1, 1'b1, 1'b0, 32'd0}, {1'b0, 1'b0, 1'b1, 32'd0},
			{1'b0, 1'b1, 1'b1, 32'd5}, {1'b0, 1'b0, 1'b1, 32'hFFFFFFFF},
			{1'b0, 1'b0, 1'b0, 32'd3}, {1'b1, 1'b0, 1'b1, 32'd7},
			{1'b1, 1'b1, 1'b1, 32'hFFFFFFFF}};
		arst_n = 0;
		cfg_we = 0; cfg_index = kmsd_pkg::REG_MXF_MODE; cfg_data = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		push_packet(kmsd_pkg::K_PLAIN, 0, 0);
		push_packet(kmsd_pkg::K_LOCAL, 0, 0);
		push_packet(kmsd_pkg::K_LOCAL, 3, 0);
		push_packet(kmsd_pkg::K_LOCAL, 20, 0);
		push_packet(kmsd_pkg::K_PRIMER, 5, 0);
		push_packet(kmsd_pkg::K_PRIMER, 0, 1);
		push_packet(kmsd_pkg::K_FILLER, 2, 0);
		push_packet(kmsd_pkg::K_PLAIN, 1, 0);
		while (byte_queue.size() < PHASE_BYTES)
			push_packet(2'($urandom_range(0, 3)), -1, -1);

		for (int p = 0; p < 7; p++) begin
			write_config(settings[p][34], settings[p][33], settings[p][32], settings[p][31:0]);
			if (p == 1) begin
				@(negedge clk);
				hold_start = 1;
				@(negedge clk);
				hold_start = 0;
			end
			idle_on = (p != 3);
			while (byte_queue.size() < PHASE_BYTES)
				push_packet(2'($urandom_range(0, 3)), -1, -1);
		end
		wait_idle();
		repeat (10) @(posedge clk);
		$display("%0d bytes checked over 8 register settings with idle and stall gaps;",
			bytes_checked);
		$display("packets closed: %0d plain, %0d local set, %0d primer, %0d filler",
			packets_seen[kmsd_pkg::K_PLAIN], packets_seen[kmsd_pkg::K_LOCAL],
			packets_seen[kmsd_pkg::K_PRIMER], packets_seen[kmsd_pkg::K_FILLER]);
		if (error_count == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end
endmodule
